>>> src/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg: shared types and constants for the site window variant counter
// Request structs, opcodes, region kinds and strand codes.
// ----------------------------------------------------------------------------
package swsc_pkg;

  localparam int VARIANT_DEPTH_DEF    = 4096;
  localparam int INTERVAL_DEPTH_DEF   = 1024;
  localparam int WINDOWS_PER_SIDE_DEF = 15;

  localparam logic [15:0] WS_RESET = 16'd2000;
  localparam int          KEY_W    = 39;   // {chrom, position}

  typedef enum logic [1:0] {
    OP_LOAD_VAR = 2'd0,
    OP_LOAD_INT = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  localparam logic [1:0] KIND_SITE = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;

  localparam logic [1:0] STRAND_GAP = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  chrom_id;
    logic [30:0] item_start;
    logic [30:0] item_end;
    logic [1:0]  strand_in;
    logic [30:0] chrom_length;
  } in_t;

  typedef struct packed {
    logic [1:0]         region_kind;
    logic [19:0]        distance_bp;
    logic [30:0]        window_start;
    logic [30:0]        window_end;
    logic signed [31:0] window_length;
    logic [12:0]        var_count;
    logic [1:0]         strand_code;
    logic               last;
  } out_t;

  // variant table control
  typedef struct packed {
    logic start;   // begin a search
    logic ins;     // insert key after upper-bound search
  } vtab_req_t;

  typedef struct packed {
    logic done;
    logic full;
  } vtab_rsp_t;

  // interval list control
  typedef struct packed {
    logic scan;
    logic load;
  } itab_req_t;

  typedef struct packed {
    logic       done;
    logic [1:0] strand;
  } itab_rsp_t;

endpackage

>>> src/swsc_vtab.sv
// ----------------------------------------------------------------------------
// swsc_vtab: sorted variant table
// Binary search over a memory with one read and one write port, and
// sorted insert by shifting entries up one at a time.
// ----------------------------------------------------------------------------
module swsc_vtab import swsc_pkg::*; #(
  parameter int VDEPTH = VARIANT_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vtab_req_t                    req,
  input  logic [KEY_W-1:0]             key,
  output vtab_rsp_t                    rsp,
  output logic [$clog2(VDEPTH+1)-1:0]  pos
);

  localparam int AW = $clog2(VDEPTH);
  localparam int CW = $clog2(VDEPTH+1);

  typedef enum logic [4:0] {
    V_IDLE = 5'b00001,
    V_RD   = 5'b00010,
    V_CMP  = 5'b00100,
    V_SHRD = 5'b01000,
    V_SHWR = 5'b10000
  } vst_t;

  vst_t             st_r, st_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt;
  logic             ins_r, ins_nxt, done_r, done_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] mem [VDEPTH];
  logic [KEY_W-1:0] rdata_r;
  logic [AW-1:0]    raddr, waddr;
  logic [KEY_W-1:0] wdata;
  logic             we;
  logic [CW:0]      sum;
  logic [CW-1:0]    mid, jm1;
  logic             go_right;

  assign sum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = sum[CW:1];
  assign jm1      = j_r - CW'(1);
  assign go_right = ins_r ? (rdata_r <= key_r) : (rdata_r < key_r);

  // table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    j_nxt    = j_r;
    ins_nxt  = ins_r;
    key_nxt  = key_r;
    done_nxt = 1'b0;
    raddr    = mid[AW-1:0];
    waddr    = j_r[AW-1:0];
    wdata    = rdata_r;
    we       = 1'b0;
    case (st_r)
      V_IDLE: begin
        if (req.start) begin
          lo_nxt  = '0;
          hi_nxt  = fill_r;
          ins_nxt = req.ins;
          key_nxt = key;
          st_nxt  = V_RD;
        end
      end
      V_RD: begin
        if (lo_r < hi_r) begin
          st_nxt = V_CMP;
        end else if (ins_r) begin
          j_nxt  = fill_r;
          st_nxt = V_SHRD;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = V_IDLE;
        end
      end
      V_CMP: begin
        if (go_right) begin
          lo_nxt = mid + CW'(1);
        end else begin
          hi_nxt = mid;
        end
        st_nxt = V_RD;
      end
      V_SHRD: begin
        raddr = jm1[AW-1:0];
        if (j_r == lo_r) begin
          we       = 1'b1;
          wdata    = key_r;
          fill_nxt = fill_r + CW'(1);
          done_nxt = 1'b1;
          st_nxt   = V_IDLE;
        end else begin
          st_nxt = V_SHWR;
        end
      end
      V_SHWR: begin
        we     = 1'b1;
        j_nxt  = jm1;
        st_nxt = V_SHRD;
      end
      default: st_nxt = V_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= V_IDLE;
      fill_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      done_r <= done_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    j_r   <= j_nxt;
    ins_r <= ins_nxt;
    key_r <= key_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.full = (fill_r == CW'(VDEPTH));
  assign pos      = lo_r;

endmodule

>>> src/swsc_itab.sv
// ----------------------------------------------------------------------------
// swsc_itab: reference interval list
// Appends intervals; scans in load order, one entry per cycle, for the
// first interval on the chromosome that holds the window.
// ----------------------------------------------------------------------------
module swsc_itab import swsc_pkg::*; #(
  parameter int IDEPTH = INTERVAL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  itab_req_t   req,
  input  logic [7:0]  chrom,
  input  logic [30:0] win_s,
  input  logic [30:0] win_e,
  input  logic [1:0]  strand,
  output itab_rsp_t   rsp
);

  localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int ICW = $clog2(IDEPTH+1);

  logic [61:0]    bnd [IDEPTH];
  logic [9:0]     tag [IDEPTH];
  logic [61:0]    bnd_rd_r;
  logic [9:0]     tag_rd_r;
  logic [ICW-1:0] fill_r, idx_r;
  logic           busy_r, pend_r, done_r, full;
  logic [1:0]     strand_r;
  logic           hit;

  assign full = (fill_r == ICW'(IDEPTH));
  assign hit  = (tag_rd_r[9:2] == chrom) && (win_s >= bnd_rd_r[61:31]) &&
                (win_e <= bnd_rd_r[30:0]);

  // list memory: append port, scan read port
  always_ff @(posedge clk) begin
    if (req.load && !full) begin
      bnd[fill_r[IAW-1:0]] <= {win_s, win_e};
      tag[fill_r[IAW-1:0]] <= {chrom, strand};
    end
    bnd_rd_r <= bnd[idx_r[IAW-1:0]];
    tag_rd_r <= tag[idx_r[IAW-1:0]];
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.load && !full) begin
        fill_r <= fill_r + ICW'(1);
      end
      if (req.scan) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else if (busy_r) begin
        if (pend_r && hit) begin
          done_r   <= 1'b1;
          strand_r <= tag_rd_r[1:0];
          busy_r   <= 1'b0;
          pend_r   <= 1'b0;
        end else if (!pend_r && idx_r == fill_r) begin
          done_r   <= 1'b1;
          strand_r <= STRAND_GAP;
          busy_r   <= 1'b0;
        end else if (idx_r < fill_r) begin
          idx_r  <= idx_r + ICW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.strand = strand_r;

endmodule

>>> src/site_window_snp_counter.sv
// ----------------------------------------------------------------------------
// site_window_snp_counter: variant counts in a site and its flanking windows
// Sequencer for window geometry, table searches and the result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request (in_t). op 0 inserts a variant into
//   the sorted table, op 1 appends a reference interval, op 2 is a site query,
//   op 3 is dropped. out_valid/out_ready carry results (out_t); a query gives
//   the site then up to WINDOWS_PER_SIDE upstream and downstream windows,
//   last set on the final one. cfg_wr_en/cfg_wr_data set the flank width.
// Sequence:
//   Interval load: appended on acceptance. Variant insert: a search, then
//   the entries above the slot are shifted up one at a time.
//   Query, per window: two binary searches, one after the other, run
//   next to the interval scan, then geometry and output; up to 31 windows
//   per query. One request at a time; in_ready is low while busy.
// Reset: synchronous, empties both tables, flank width back to 2000.
// Stall: a held result blocks the sequencer until out_ready takes it.
// ----------------------------------------------------------------------------
module site_window_snp_counter import swsc_pkg::*; #(
  parameter int VARIANT_DEPTH    = VARIANT_DEPTH_DEF,
  parameter int INTERVAL_DEPTH   = INTERVAL_DEPTH_DEF,
  parameter int WINDOWS_PER_SIDE = WINDOWS_PER_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int CW = $clog2(VARIANT_DEPTH+1);

  typedef enum logic [7:0] {
    T_IDLE = 8'b00000001,
    T_LOAD = 8'b00000010,
    T_CNT1 = 8'b00000100,
    T_CNT2 = 8'b00001000,
    T_CNT3 = 8'b00010000,
    T_CNT4 = 8'b00100000,
    T_FIND = 8'b01000000,
    T_OUT  = 8'b10000000
  } tst_t;

  typedef enum logic [2:0] {
    PH_UP   = 3'b001,
    PH_DOWN = 3'b010,
    PH_END  = 3'b100
  } phase_t;

  tst_t          state_r;
  phase_t        phase_r;
  logic [15:0]   ws_r;
  logic [7:0]    chrom_r;
  logic [30:0]   s_r, e_r, lim_r;
  logic [3:0]    k_r;
  logic [19:0]   off_r;
  // window being counted
  logic [1:0]    cur_kind_r;
  logic [19:0]   cur_dist_r;
  logic [30:0]   cur_s_r, cur_e_r;
  // next emitted window
  logic          nxt_found_r;
  logic [1:0]    nxt_kind_r;
  logic [19:0]   nxt_dist_r;
  logic [30:0]   nxt_s_r, nxt_e_r;
  logic [CW-1:0] lbe_r, lbs_r;
  logic          idone_r;
  logic [1:0]    strand_r;
  logic          out_valid_r;
  out_t          out_r;

  vtab_req_t        vreq;
  vtab_rsp_t        vrsp;
  logic [KEY_W-1:0] vkey;
  logic [CW-1:0]    vpos;
  itab_req_t        ireq;
  itab_rsp_t        irsp;
  logic             in_acc;
  logic [CW-1:0]    cnt;

  // window geometry, 33-bit signed
  logic signed [32:0] up_w0, up_w1, dn_w0, dn_w1, lim_x;

  assign in_ready = (state_r == T_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign lim_x    = {2'b00, lim_r};
  assign up_w0    = {2'b00, s_r} - {13'd0, off_r};
  assign up_w1    = up_w0 + {17'd0, ws_r};
  assign dn_w1    = {2'b00, e_r} + {13'd0, off_r};
  assign dn_w0    = dn_w1 - {17'd0, ws_r};
  assign cnt      = (cur_e_r > cur_s_r) ? (lbe_r - lbs_r) : '0;

  // table requests
  always_comb begin
    vreq.start = 1'b0;
    vreq.ins   = 1'b0;
    vkey       = {chrom_r, cur_e_r};
    ireq.scan  = 1'b0;
    ireq.load  = 1'b0;
    if (in_acc && in_data.op == OP_LOAD_VAR && !vrsp.full) begin
      vreq.start = 1'b1;
      vreq.ins   = 1'b1;
      vkey       = {in_data.chrom_id, in_data.item_start};
    end
    if (in_acc && in_data.op == OP_LOAD_INT) begin
      ireq.load = 1'b1;
    end
    if (state_r == T_CNT1) begin
      vreq.start = 1'b1;
      ireq.scan  = 1'b1;
    end
    if (state_r == T_CNT2 && vrsp.done) begin
      vreq.start = 1'b1;
      vkey       = {chrom_r, cur_s_r};
    end
  end

  swsc_vtab #(.VDEPTH(VARIANT_DEPTH)) u_vtab (
    .clk, .rst_n, .req(vreq), .key(vkey), .rsp(vrsp), .pos(vpos)
  );

  swsc_itab #(.IDEPTH(INTERVAL_DEPTH)) u_itab (
    .clk, .rst_n, .req(ireq),
    .chrom (ireq.load ? in_data.chrom_id   : chrom_r),
    .win_s (ireq.load ? in_data.item_start : cur_s_r),
    .win_e (ireq.load ? in_data.item_end   : cur_e_r),
    .strand(in_data.strand_in),
    .rsp   (irsp)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_RESET;
    end else if (cfg_wr_en) begin
      ws_r <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      idone_r     <= 1'b0;
      phase_r     <= PH_UP;
    end else begin
      // T_OUT handles the result register itself
      if (out_valid_r && out_ready && state_r != T_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (irsp.done) begin
        idone_r  <= 1'b1;
        strand_r <= irsp.strand;
      end
      case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            chrom_r    <= in_data.chrom_id;
            s_r        <= in_data.item_start;
            e_r        <= in_data.item_end;
            lim_r      <= in_data.chrom_length;
            cur_kind_r <= KIND_SITE;
            cur_dist_r <= '0;
            cur_s_r    <= in_data.item_start;
            cur_e_r    <= in_data.item_end;
            phase_r    <= PH_UP;
            k_r        <= 4'd1;
            off_r      <= {4'd0, ws_r};
            if (in_data.op == OP_LOAD_VAR && !vrsp.full) begin
              state_r <= T_LOAD;
            end else if (in_data.op == OP_QUERY) begin
              state_r <= T_CNT1;
            end
          end
        end
        T_LOAD: begin
          if (vrsp.done) begin
            state_r <= T_IDLE;
          end
        end
        T_CNT1: begin
          idone_r <= 1'b0;
          state_r <= T_CNT2;
        end
        T_CNT2: begin
          if (vrsp.done) begin
            lbe_r   <= vpos;
            state_r <= T_CNT3;
          end
        end
        T_CNT3: begin
          if (vrsp.done) begin
            lbs_r   <= vpos;
            state_r <= T_CNT4;
          end
        end
        T_CNT4: begin
          if (idone_r) begin
            nxt_found_r <= 1'b0;
            state_r     <= T_FIND;
          end
        end
        T_FIND: begin
          case (phase_r)
            PH_UP: begin
              nxt_kind_r <= KIND_UP;
              nxt_dist_r <= off_r;
              // clip at position zero
              nxt_s_r    <= up_w0[32] ? 31'd0 : up_w0[30:0];
              nxt_e_r    <= up_w1[30:0];
              if (up_w0[32]) begin
                if (!up_w1[32] && up_w1 != '0) begin
                  nxt_found_r <= 1'b1;
                  state_r     <= T_OUT;
                end
                phase_r <= PH_DOWN;
                k_r     <= 4'd1;
                off_r   <= {4'd0, ws_r};
              end else begin
                nxt_found_r <= 1'b1;
                state_r     <= T_OUT;
                if (k_r == 4'(WINDOWS_PER_SIDE)) begin
                  phase_r <= PH_DOWN;
                  k_r     <= 4'd1;
                  off_r   <= {4'd0, ws_r};
                end else begin
                  k_r   <= k_r + 4'd1;
                  off_r <= off_r + {4'd0, ws_r};
                end
              end
            end
            PH_DOWN: begin
              nxt_kind_r <= KIND_DOWN;
              nxt_dist_r <= off_r;
              nxt_s_r    <= dn_w0[30:0];
              // clip at the chromosome length
              nxt_e_r    <= (dn_w1 > lim_x) ? lim_r : dn_w1[30:0];
              if (dn_w1 > lim_x) begin
                if (dn_w0 < lim_x) begin
                  nxt_found_r <= 1'b1;
                end
                phase_r <= PH_END;
              end else begin
                nxt_found_r <= 1'b1;
                if (k_r == 4'(WINDOWS_PER_SIDE)) begin
                  phase_r <= PH_END;
                end else begin
                  k_r   <= k_r + 4'd1;
                  off_r <= off_r + {4'd0, ws_r};
                end
              end
              state_r <= T_OUT;
            end
            default: state_r <= T_OUT;
          endcase
        end
        T_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_r.region_kind       <= cur_kind_r;
            out_r.distance_bp       <= cur_dist_r;
            out_r.window_start      <= cur_s_r;
            out_r.window_end        <= cur_e_r;
            out_r.window_length     <= {1'b0, cur_e_r} - {1'b0, cur_s_r};
            out_r.var_count         <= 13'(cnt);
            out_r.strand_code       <= strand_r;
            out_r.last              <= !nxt_found_r;
            if (nxt_found_r) begin
              cur_kind_r <= nxt_kind_r;
              cur_dist_r <= nxt_dist_r;
              cur_s_r    <= nxt_s_r;
              cur_e_r    <= nxt_e_r;
              state_r    <= T_CNT1;
            end else begin
              state_r <= T_IDLE;
            end
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // search results only arrive while the sequencer waits for them
  a_vdone_expected: assert property (@(posedge clk) disable iff (!rst_n)
    vrsp.done |-> (state_r == T_LOAD || state_r == T_CNT2 || state_r == T_CNT3))
    else $error("variant table response with no search pending");

  // one scan result per window
  a_idone_once: assert property (@(posedge clk) disable iff (!rst_n)
    irsp.done |-> !idone_r && state_r != T_IDLE)
    else $error("interval scan finished twice or while idle");

  // a result is issued only after the scan finished
  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_OUT) |-> idone_r)
    else $error("result issued before interval scan completed");

endmodule

>>> verif/tb_site_window_snp_counter.sv
// ----------------------------------------------------------------------------
// tb_site_window_snp_counter: self-checking bench for the site window counter
// Loads variants and reference intervals, issues site queries under random
// idling on both channels, and checks every result against a local model.
// ----------------------------------------------------------------------------
module tb_site_window_snp_counter;
  import swsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VDEPTH    = 4096;
  localparam int IDEPTH    = 1024;
  localparam int WPS       = 15;
  localparam int MAX_CYC   = 3000000;
  localparam int DRAIN_CYC = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  site_window_snp_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // local model state
  logic [38:0] snp_keys[$];
  logic [61:0] ref_bounds[$];
  logic [9:0]  ref_tags[$];
  logic [15:0] win_size;

  in_t  pending_reqs[$];
  out_t expected_windows[$];
  int   errors;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycle_cnt;
  logic req_accepted;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic add_req(input in_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // first table index whose key is >= key
  function automatic int first_at_or_above(input logic [38:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = snp_keys.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (snp_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic out_t make_window(input logic [1:0] kind, input longint offset_bp,
                                       input logic [7:0] chrom, input longint s,
                                       input longint e);
    out_t r;
    int   cnt;
    r = '0;
    r.region_kind   = kind;
    r.distance_bp   = offset_bp[19:0];
    r.window_start  = s[30:0];
    r.window_end    = e[30:0];
    r.window_length = 32'(e - s);
    cnt = 0;
    if (e > s)
      cnt = first_at_or_above({chrom, e[30:0]}) - first_at_or_above({chrom, s[30:0]});
    r.var_count   = cnt[12:0];
    r.strand_code = STRAND_GAP;
    foreach (ref_bounds[i]) begin
      if (ref_tags[i][9:2] == chrom && s >= longint'(ref_bounds[i][61:31])
          && e <= longint'(ref_bounds[i][30:0])) begin
        r.strand_code = ref_tags[i][1:0];
        break;
      end
    end
    return r;
  endfunction

  // apply one accepted request to the model and queue the windows it yields
  task automatic predict_request(input in_t req);
    longint ws;
    longint off;
    longint w0;
    longint w1;
    longint lim;
    int     pos;
    out_t   q[$];
    ws  = longint'(win_size);
    lim = longint'(req.chrom_length);
    case (op_t'(req.op))
      OP_LOAD_VAR: begin
        if (snp_keys.size() < VDEPTH) begin
          pos = 0;
          while (pos < snp_keys.size() && snp_keys[pos] <= {req.chrom_id, req.item_start})
            pos++;
          snp_keys.insert(pos, {req.chrom_id, req.item_start});
        end
      end
      OP_LOAD_INT: begin
        if (ref_bounds.size() < IDEPTH) begin
          ref_bounds.insert(ref_bounds.size(), {req.item_start, req.item_end});
          ref_tags.insert(ref_tags.size(), {req.chrom_id, req.strand_in});
        end
      end
      OP_QUERY: begin
        q.insert(q.size(), make_window(KIND_SITE, 0, req.chrom_id, req.item_start,
                                       req.item_end));
        for (int k = 1; k <= WPS; k++) begin
          off = k * ws;
          w0 = longint'(req.item_start) - off;
          w1 = w0 + ws;
          if (w0 < 0) begin
            if (w1 > 0) q.insert(q.size(), make_window(KIND_UP, off, req.chrom_id, 0, w1));
            break;
          end
          q.insert(q.size(), make_window(KIND_UP, off, req.chrom_id, w0, w1));
        end
        for (int k = 1; k <= WPS; k++) begin
          off = k * ws;
          w1 = longint'(req.item_end) + off;
          w0 = w1 - ws;
          if (w1 > lim) begin
            if (w0 < lim)
              q.insert(q.size(), make_window(KIND_DOWN, off, req.chrom_id, w0, lim));
            break;
          end
          q.insert(q.size(), make_window(KIND_DOWN, off, req.chrom_id, w0, w1));
        end
        q[q.size()-1].last = 1'b1;
        foreach (q[i]) expected_windows.insert(expected_windows.size(), q[i]);
      end
      default: ;
    endcase
  endtask

  function automatic in_t mk_req(input op_t op, input int chrom, input longint s,
                                 input longint e, input int strand, input longint lim);
    in_t r;
    r.op           = op;
    r.chrom_id     = chrom[7:0];
    r.item_start   = s[30:0];
    r.item_end     = e[30:0];
    r.strand_in    = strand[1:0];
    r.chrom_length = lim[30:0];
    return r;
  endfunction

  function automatic logic [30:0] rnd31();
    return 31'($urandom());
  endfunction

  // driver: launch requests from the pending queue at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_accepted) begin
      // hold the current request
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data  <= pending_reqs.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: requests into the model, results against expectations
  always @(posedge clk) begin
    req_accepted = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) predict_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_windows.size() == 0) begin
          report_mismatch("unexpected result kind", out_data.region_kind, -1);
        end else begin
          out_t x;
          x = expected_windows.pop_front();
          if (out_data.region_kind !== x.region_kind)
            report_mismatch("region_kind", out_data.region_kind, x.region_kind);
          if (out_data.distance_bp !== x.distance_bp)
            report_mismatch("distance_bp", out_data.distance_bp, x.distance_bp);
          if (out_data.window_start !== x.window_start)
            report_mismatch("window_start", out_data.window_start, x.window_start);
          if (out_data.window_end !== x.window_end)
            report_mismatch("window_end", out_data.window_end, x.window_end);
          if (out_data.window_length !== x.window_length)
            report_mismatch("window_length", out_data.window_length, x.window_length);
          if (out_data.var_count !== x.var_count)
            report_mismatch("var_count", out_data.var_count, x.var_count);
          if (out_data.strand_code !== x.strand_code)
            report_mismatch("strand_code", out_data.strand_code, x.strand_code);
          if (out_data.last !== x.last)
            report_mismatch("last", out_data.last, x.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYC) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || !in_ready || expected_windows.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_win_width(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    win_size = v;
  endtask

  // random mix centered on a few chromosomes so queries hit loaded data
  task automatic queue_random(input int n);
    int     c;
    longint s;
    longint len;
    int     pick;
    for (int i = 0; i < n; i++) begin
      c    = $urandom_range(3);
      if ($urandom_range(9) == 0) c = $urandom_range(255);
      s    = $urandom_range(60000);
      pick = $urandom_range(99);
      if (pick < 4) begin
        add_req(mk_req(op_t'(rnd31() % 4), $urandom_range(255), rnd31(),
                       rnd31(), $urandom_range(3), rnd31()));
      end else if (pick < 45) begin
        if ($urandom_range(9) == 0) s = rnd31();
        add_req(mk_req(OP_LOAD_VAR, c, s, rnd31(), $urandom_range(3), rnd31()));
      end else if (pick < 60) begin
        len = $urandom_range(80000);
        if ($urandom_range(4) == 0) len = 2147483647 - s;
        add_req(mk_req(OP_LOAD_INT, c, s, s + len, $urandom_range(3), rnd31()));
      end else begin
        len = $urandom_range(3000);
        if ($urandom_range(7) == 0) len = -longint'($urandom_range(500));
        add_req(mk_req(OP_QUERY, c, s + 500, s + 500 + len, $urandom_range(3),
                       s + len + $urandom_range(40000)));
      end
    end
  endtask

  initial begin
    errors        = 0;
    cycle_cnt     = 0;
    req_accepted  = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    win_size      = WS_RESET;
    send_idle_pct = 17;
    recv_idle_pct = 72;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: query an empty table at the reset window size, then extremes
    add_req(mk_req(OP_QUERY, 0, 10000, 12000, 0, 50000));
    add_req(mk_req(OP_LOAD_VAR, 0, 0, 0, 0, 0));
    add_req(mk_req(OP_LOAD_VAR, 0, 10500, 0, 0, 0));
    add_req(mk_req(OP_LOAD_VAR, 0, 10500, 0, 0, 0));  // duplicate
    add_req(mk_req(OP_LOAD_VAR, 255, 2147483647, 0, 0, 0));
    add_req(mk_req(OP_LOAD_VAR, 0, 7999, 0, 0, 0));
    add_req(mk_req(OP_LOAD_INT, 0, 0, 2147483647, 1, 0));
    add_req(mk_req(OP_LOAD_INT, 0, 9000, 13000, 0, 0));
    add_req(mk_req(OP_LOAD_INT, 1, 0, 100, 3, 0));     // strand three
    add_req(mk_req(OP_LOAD_INT, 255, 100, 200, 2, 0));
    add_req(mk_req(OP_NONE, 255, 2147483647, 2147483647, 3, 2147483647));
    add_req(mk_req(OP_QUERY, 0, 10000, 12000, 2, 50000));
    add_req(mk_req(OP_QUERY, 0, 1000, 1500, 0, 1800));  // clipped both sides
    add_req(mk_req(OP_QUERY, 0, 12000, 10000, 0, 90000)); // reversed site
    add_req(mk_req(OP_QUERY, 1, 0, 50, 0, 0));
    add_req(mk_req(OP_QUERY, 255, 2147483000, 2147483647, 0, 2147483647));
    add_req(mk_req(OP_QUERY, 255, 150, 160, 0, 2147483647));
    wait_drained();

    // phase 1: sender idles lightly, receiver heavily; largest window size
    set_win_width(16'hFFFF);
    send_idle_pct = 17;
    recv_idle_pct = 72;
    add_req(mk_req(OP_QUERY, 0, 2147483647, 2147483647, 0, 2147483647));
    add_req(mk_req(OP_QUERY, 0, 0, 0, 0, 0));
    queue_random(35);
    wait_drained();

    // phase 2: roles swapped, size 1, then size 0, then a mid value
    set_win_width(16'd1);
    send_idle_pct = 72;
    recv_idle_pct = 17;
    queue_random(15);
    wait_drained();
    set_win_width(16'd0);  // zero size is taken as is
    add_req(mk_req(OP_QUERY, 0, 10000, 12000, 0, 50000));
    wait_drained();
    set_win_width(16'd3000);
    queue_random(20);
    wait_drained();

    // phase 3: no idling
    set_win_width(16'd777);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(10);
    wait_drained();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
